FILE: rtl/tbr_pkg.sv
// ----------------------------------------------------------------------------
// tbr_pkg: shared types and constants of the TOF bin range block
// Field widths, the queue word, the divider lane and its step function.
// ----------------------------------------------------------------------------
`default_nettype none

package tbr_pkg;

	localparam int COORD_W  = 32;
	localparam int DIR_W    = 18;
	localparam int DIFF_W   = COORD_W + 1;
	localparam int PROD_W   = DIFF_W + DIR_W;
	localparam int PROJ_W   = PROD_W + 2;
	localparam int BW_W     = 31;
	localparam int SIG_W    = 31;
	localparam int CNT_W    = 8;
	localparam int SPREAD_W = SIG_W + CNT_W;
	localparam int HALF_W   = 12;
	localparam int BIN_W    = 13;
	localparam int NUM_W    = 56;
	localparam int MAG_W    = NUM_W + 1;
	localparam int QUO_W    = HALF_W + 1;   // top bit flags a quotient of 4096 or more
	localparam int CFG_W    = 32;
	localparam int ADDR_W   = 3;

	typedef enum logic [ADDR_W-1:0] {
		REG_BIN_WIDTH  = 3'd0,
		REG_CENTER_OFF = 3'd1,
		REG_SIGMA      = 3'd2,
		REG_SIGMA_CNT  = 3'd3,
		REG_HALF_BINS  = 3'd4
	} reg_idx_t;

	// numerators handed from front to back; the high one is already negated
	typedef struct packed {
		logic signed [NUM_W-1:0] num_lo;
		logic signed [NUM_W-1:0] num_hi;
	} work_t;

	typedef struct packed {
		logic             neg;
		logic [MAG_W-1:0] rem;
		logic [QUO_W-1:0] quo;
	} lane_t;

	// one restoring-division step for quotient bit k
	function automatic lane_t div_step(lane_t l, logic [BW_W-1:0] d, int k);
		lane_t            r;
		logic [MAG_W-1:0] sd;
		r  = l;
		sd = MAG_W'(d) << k;
		if (l.rem >= sd) begin
			r.rem    = l.rem - sd;
			r.quo[k] = 1'b1;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/tof_bin_range.sv
// ----------------------------------------------------------------------------
// tof_bin_range: TOF bin range of a voxel along a line of response
// Projects the voxel offset onto the line, widens by sigma_count * sigma and
// gives floor/ceil bins of the two ends, clamped to +/- half_bins.
// ----------------------------------------------------------------------------
//
//  channel   dir  words                  payload
//  s_*       in   one line/voxel pair    s_tdata, 248 bits
//  m_*       out  one bin pair per input m_tdata, 32 bits
//  cfg_*     in   register writes        cfg_addr, cfg_wdata
//
//  Cycles: one word a cycle sustained while m_tready is high.
//  Front is a fixed 4-stage projection pipe (3 multipliers, one sum stage).
//  Back is a prep stage and a 13-stage restoring divider, one quotient bit
//  per stage, plus an output register; it stalls as a whole when m_tready
//  is low while its output register holds a result.
//  s_tready follows a credit count over front pipe and queue (QUEUE_DEPTH).
//  Reset: asynchronous, clears control and restores register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module tof_bin_range
	import tbr_pkg::*;
#(
	parameter int DIR_FRAC_BITS = 16,
	parameter int QUEUE_DEPTH   = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	// mid_x, mid_y, mid_z, vox_x, vox_y, vox_z, dir_x, dir_y, dir_z, 2 pad
	input  wire logic [247:0]      s_tdata,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	// low_bin, high_bin, 6 pad
	output logic [31:0]            m_tdata,
	input  wire logic              cfg_we,
	input  wire logic [ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_W-1:0]  cfg_wdata
);

	localparam int USED_W = $clog2(QUEUE_DEPTH + 1);

	// configuration registers
	logic [BW_W-1:0]           bin_width_q;
	logic signed [COORD_W-1:0] center_offset_q;
	logic [SIG_W-1:0]          sigma_q;
	logic [CNT_W-1:0]          sigma_count_q;
	logic [HALF_W-1:0]         half_bins_q;
	// derived, settle while idle
	logic [BW_W-1:0]           bw_eff_q;
	logic [SPREAD_W-1:0]       spread_q;

	logic              accept;
	logic [USED_W-1:0] used_q;
	logic              f_valid;
	work_t             f_word;
	logic              q_avail;
	work_t             q_word;
	logic              b_pop;
	logic signed [BIN_W-1:0] low_bin, high_bin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_width_q     <= BW_W'(65536);
			center_offset_q <= '0;
			sigma_q         <= SIG_W'(65536);
			sigma_count_q   <= CNT_W'(3);
			half_bins_q     <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_addr))
				REG_BIN_WIDTH:  bin_width_q     <= cfg_wdata[BW_W-1:0];
				REG_CENTER_OFF: center_offset_q <= cfg_wdata;
				REG_SIGMA:      sigma_q         <= cfg_wdata[SIG_W-1:0];
				REG_SIGMA_CNT:  sigma_count_q   <= cfg_wdata[CNT_W-1:0];
				REG_HALF_BINS:  half_bins_q     <= cfg_wdata[HALF_W-1:0];
				default: ;
			endcase
		end
	end

	// zero width acts as one LSB
	always_ff @(posedge clk) begin
		bw_eff_q <= (bin_width_q == '0) ? BW_W'(1) : bin_width_q;
		spread_q <= SPREAD_W'(sigma_count_q) * SPREAD_W'(sigma_q);
	end

	// credits: words in the front pipe plus words in the queue
	assign accept   = s_tvalid && s_tready;
	assign s_tready = (used_q < USED_W'(QUEUE_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else begin
			used_q <= used_q + USED_W'(accept) - USED_W'(b_pop);
		end
	end

	tbr_front #(
		.DIR_FRAC_BITS(DIR_FRAC_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (accept),
		.mid_x        (s_tdata[31:0]),
		.mid_y        (s_tdata[63:32]),
		.mid_z        (s_tdata[95:64]),
		.vox_x        (s_tdata[127:96]),
		.vox_y        (s_tdata[159:128]),
		.vox_z        (s_tdata[191:160]),
		.dir_x        (s_tdata[209:192]),
		.dir_y        (s_tdata[227:210]),
		.dir_z        (s_tdata[245:228]),
		.center_offset(center_offset_q),
		.spread       (spread_q),
		.out_valid    (f_valid),
		.out_word     (f_word)
	);

	tbr_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (f_valid),
		.push_word(f_word),
		.pop      (b_pop),
		.avail    (q_avail),
		.head_word(q_word)
	);

	tbr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (q_avail),
		.in_word  (q_word),
		.pop      (b_pop),
		.bin_width(bw_eff_q),
		.half_bins(half_bins_q),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.low_bin  (low_bin),
		.high_bin (high_bin)
	);

	assign m_tdata = {6'b0, high_bin, low_bin};

endmodule

`default_nettype wire

FILE: rtl/tbr_queue.sv
// ----------------------------------------------------------------------------
// tbr_queue: small register FIFO between front and back
// Show-ahead read; the caller guarantees no push while full.
// ----------------------------------------------------------------------------
`default_nettype none

module tbr_queue
	import tbr_pkg::*;
#(
	parameter int DEPTH = 8
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire work_t push_word,
	input  wire logic  pop,
	output logic       avail,
	output work_t      head_word
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	work_t              mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [CNT_W-1:0]   cnt_q;

	assign avail     = (cnt_q != '0);
	assign head_word = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

FILE: rtl/tbr_front.sv
// ----------------------------------------------------------------------------
// tbr_front: projection front end
// Offset, three products, sum and floor/ceil, then both bin numerators.
// ----------------------------------------------------------------------------
`default_nettype none

module tbr_front
	import tbr_pkg::*;
#(
	parameter int DIR_FRAC_BITS = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	input  wire logic signed [COORD_W-1:0]  mid_x,
	input  wire logic signed [COORD_W-1:0]  mid_y,
	input  wire logic signed [COORD_W-1:0]  mid_z,
	input  wire logic signed [COORD_W-1:0]  vox_x,
	input  wire logic signed [COORD_W-1:0]  vox_y,
	input  wire logic signed [COORD_W-1:0]  vox_z,
	input  wire logic signed [DIR_W-1:0]    dir_x,
	input  wire logic signed [DIR_W-1:0]    dir_y,
	input  wire logic signed [DIR_W-1:0]    dir_z,
	input  wire logic signed [COORD_W-1:0]  center_offset,
	input  wire logic [SPREAD_W-1:0]        spread,
	output logic                            out_valid,
	output work_t                           out_word
);

	logic                      v_s1, v_s2, v_s3, v_s4;
	logic signed [DIFF_W-1:0]  dx_s1, dy_s1, dz_s1;
	logic signed [DIR_W-1:0]   ux_s1, uy_s1, uz_s1;
	logic signed [PROD_W-1:0]  px_s2, py_s2, pz_s2;
	logic signed [PROJ_W-1:0]  proj_s3;
	logic signed [PROJ_W-1:0]  pf, pc;
	work_t                     word_s4;

	// floor and ceiling of the projection back to coordinate scale
	assign pf = proj_s3 >>> DIR_FRAC_BITS;
	assign pc = -((-proj_s3) >>> DIR_FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1   <= DIFF_W'(vox_x) - DIFF_W'(mid_x);
		dy_s1   <= DIFF_W'(vox_y) - DIFF_W'(mid_y);
		dz_s1   <= DIFF_W'(vox_z) - DIFF_W'(mid_z);
		ux_s1   <= dir_x;
		uy_s1   <= dir_y;
		uz_s1   <= dir_z;
		px_s2   <= PROD_W'(dx_s1) * PROD_W'(ux_s1);
		py_s2   <= PROD_W'(dy_s1) * PROD_W'(uy_s1);
		pz_s2   <= PROD_W'(dz_s1) * PROD_W'(uz_s1);
		proj_s3 <= PROJ_W'(px_s2) + PROJ_W'(py_s2) + PROJ_W'(pz_s2);
		word_s4.num_lo <= NUM_W'(pf) - NUM_W'(center_offset) - NUM_W'(spread);
		word_s4.num_hi <= NUM_W'(center_offset) - NUM_W'(spread) - NUM_W'(pc);
	end

	assign out_valid = v_s4;
	assign out_word  = word_s4;

endmodule

`default_nettype wire

FILE: rtl/tbr_back.sv
// ----------------------------------------------------------------------------
// tbr_back: pipelined floor division by the bin width and clamping
// Two lanes (low and negated high), one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tbr_back
	import tbr_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire work_t              in_word,
	output logic                    pop,
	input  wire logic [BW_W-1:0]    bin_width,
	input  wire logic [HALF_W-1:0]  half_bins,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [BIN_W-1:0] low_bin,
	output logic signed [BIN_W-1:0] high_bin
);

	localparam int NS = QUO_W + 1;   // prep stage plus one per quotient bit

	logic              adv;
	logic              v_q  [NS];
	lane_t             lo_q [NS];
	lane_t             hi_q [NS];
	logic              ov_q;
	logic signed [BIN_W-1:0] low_q, high_q;

	function automatic lane_t prep(logic signed [NUM_W-1:0] n, logic [BW_W-1:0] d);
		lane_t l;
		l.neg = n[NUM_W-1];
		// negative: |n| + d - 1 == ~n + d
		l.rem = l.neg ? ({1'b0, ~n} + MAG_W'(d)) : {1'b0, n};
		l.quo = '0;
		return l;
	endfunction

	function automatic logic signed [BIN_W-1:0] finish(lane_t l, logic flip,
			logic [HALF_W-1:0] lim);
		logic [QUO_W-1:0]         qm;
		logic signed [QUO_W:0]    v;
		logic signed [QUO_W:0]    sl;
		qm = l.quo[QUO_W-1] ? {1'b1, {(QUO_W-1){1'b0}}} : l.quo;
		v  = (l.neg ^ flip) ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
		sl = $signed({2'b00, lim});
		if (v > sl) begin
			v = sl;
		end else if (v < -sl) begin
			v = -sl;
		end
		return BIN_W'(v);
	endfunction

	assign adv = !ov_q || out_ready;
	assign pop = adv && in_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NS; i++) begin
				v_q[i] <= 1'b0;
			end
			ov_q <= 1'b0;
		end else if (adv) begin
			v_q[0] <= in_valid;
			for (int i = 1; i < NS; i++) begin
				v_q[i] <= v_q[i-1];
			end
			ov_q <= v_q[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lo_q[0] <= prep(in_word.num_lo, bin_width);
			hi_q[0] <= prep(in_word.num_hi, bin_width);
			low_q   <= finish(lo_q[NS-1], 1'b0, half_bins);
			high_q  <= finish(hi_q[NS-1], 1'b1, half_bins);
		end
	end

	for (genvar g = 1; g < NS; g++) begin : g_step
		always_ff @(posedge clk) begin
			if (adv) begin
				lo_q[g] <= div_step(lo_q[g-1], bin_width, NS - 1 - g);
				hi_q[g] <= div_step(hi_q[g-1], bin_width, NS - 1 - g);
			end
		end
	end

	assign out_valid = ov_q;
	assign low_bin   = low_q;
	assign high_bin  = high_q;

endmodule

`default_nettype wire
